[src/mad_pkg.sv]
package mad_pkg;

  // Field widths
  localparam int SAMPLE_W = 32;
  localparam int WINDOW_W = 9;

  // Configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] REG_WINDOW_SIZE = '0;

  // Defaults
  localparam int MAX_WINDOW_DEFAULT = 256;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd8;

  // Item sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ACCUM,
    ST_DIVIDE
  } state_t;

endpackage

[src/moving_average_damper.sv]
// Moving-average damper: emits the truncated mean of the most recent
// window_size Q16.16 samples (or of all samples since the last clear while
// the window is still filling).
//
// Input channel: in_valid / in_ready with payload sample. Output channel:
// out_valid / out_ready with payload mean, one result per transaction.
// window_size sits at APB address 0; any write to it clears the history.
//
// Each sample is carried through to its result before the next is accepted:
// the sequencer steps from IDLE through UPDATE, ACCUM and DIVIDE and back.
// The bit-serial restoring divider is SUM_W = 32 + clog2(MAX_WINDOW + 1)
// bits wide and produces one quotient bit per cycle. One ring-store read
// and one write occur per sample.
//
// Reset (synchronous, rst high) sets window_size to 8 and empties the window.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and worked on, and its result waits in the divider
// until the output register frees up.
module moving_average_damper #(
  parameter int MAX_WINDOW = mad_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // Sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mad_pkg::SAMPLE_W-1:0]  sample,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mad_pkg::SAMPLE_W-1:0]  mean,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mad_pkg::ADDR_W-1:0]    paddr,
  input  logic [mad_pkg::DATA_W-1:0]    pwdata,
  output logic [mad_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = mad_pkg::SAMPLE_W + CW;

  logic [mad_pkg::WINDOW_W-1:0] window_size;
  logic [CW-1:0]                eff_window;

  logic [AW-1:0]                write_slot;
  logic [AW-1:0]                cur_slot;
  logic [CW-1:0]                fill_count;
  logic [SUM_W-1:0]             running_sum;
  logic [mad_pkg::SAMPLE_W-1:0] sample_hold;
  logic [mad_pkg::SAMPLE_W-1:0] old_sample;

  logic [mad_pkg::SAMPLE_W-1:0] history [MAX_WINDOW];

  mad_pkg::state_t state, state_next;

  logic             cfg_write;
  logic             accept;
  logic             out_free;
  logic             do_update;
  logic             div_start;
  logic             load_out;
  logic             full;
  logic [AW-1:0]    slot_in;
  logic [CW:0]      slot_inc;
  logic [SUM_W-1:0] sum_plus;
  logic             div_busy;
  logic [SUM_W-1:0] div_quotient;

  // Configuration access
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready
                     & (paddr == mad_pkg::REG_WINDOW_SIZE);
  assign prdata    = (paddr == mad_pkg::REG_WINDOW_SIZE)
                     ? mad_pkg::DATA_W'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= mad_pkg::WINDOW_RESET;
    end else if (cfg_write) begin
      window_size <= pwdata[mad_pkg::WINDOW_W-1:0];
    end
  end

  // Clamp the window to 1..MAX_WINDOW
  always_comb begin
    if (window_size == '0) begin
      eff_window = CW'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      eff_window = CW'(MAX_WINDOW);
    end else begin
      eff_window = CW'(window_size);
    end
  end

  // Slot arithmetic and sums
  assign slot_in  = (CW'(write_slot) >= eff_window) ? '0 : write_slot;
  assign slot_inc = (CW + 1)'(cur_slot) + 1'b1;
  assign full     = (fill_count >= eff_window);
  assign sum_plus = running_sum + SUM_W'(sample_hold);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mad_pkg::ST_IDLE:   if (accept) state_next = mad_pkg::ST_UPDATE;
      mad_pkg::ST_UPDATE: state_next = mad_pkg::ST_ACCUM;
      mad_pkg::ST_ACCUM:  state_next = mad_pkg::ST_DIVIDE;
      mad_pkg::ST_DIVIDE: if (!div_busy && out_free) state_next = mad_pkg::ST_IDLE;
      default:            state_next = mad_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    do_update = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      mad_pkg::ST_IDLE:   in_ready  = 1'b1;
      mad_pkg::ST_UPDATE: do_update = 1'b1;
      mad_pkg::ST_ACCUM:  div_start = 1'b1;
      mad_pkg::ST_DIVIDE: load_out  = ~div_busy & out_free;
      default:            in_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the sample and read the oldest entry at the slot in use
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_hold <= sample;
      cur_slot    <= slot_in;
      old_sample  <= history[slot_in];
    end
  end

  // Overwrite the oldest entry with the new sample
  always_ff @(posedge clk) begin
    if (do_update) begin
      history[cur_slot] <= sample_hold;
    end
  end

  // Window bookkeeping: drop the oldest sample, then add the new one
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      write_slot  <= '0;
      fill_count  <= '0;
      running_sum <= '0;
    end else if (do_update) begin
      if (full) begin
        running_sum <= running_sum - SUM_W'(old_sample);
        fill_count  <= eff_window;
      end else begin
        fill_count  <= fill_count + 1'b1;
      end
      write_slot <= (slot_inc >= (CW + 1)'(eff_window)) ? '0 : cur_slot + 1'b1;
    end else if (div_start) begin
      running_sum <= sum_plus;
    end
  end

  mad_divider #(
    .NUM_W (SUM_W),
    .DEN_W (CW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_plus),
    .divisor  (fill_count),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      mean <= div_quotient[mad_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

[src/mad_divider.sv]
module mad_divider #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;

  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   diff;
  logic             qbit;
  logic [DEN_W-1:0] rem_next;

  // Restoring step: bring in one dividend bit, try to subtract the divisor
  always_comb begin
    rem_shift = {rem, quo[NUM_W-1]};
    diff      = rem_shift - {1'b0, den};
    qbit      = ~diff[DEN_W];
    rem_next  = qbit ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
  end

  // Shift the dividend out and the quotient in, one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
      quo  <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], qbit};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

endmodule
